@@ hw/rtl/pma_pkg.sv @@
// Shared types, constants and the rounding helper for the polarisation matrix apply unit.
`default_nettype none

package pma_pkg;

  // one complex value: real part in the upper half, imaginary in the lower
  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } cpx_t;

  localparam int PART_W    = 16;
  localparam int FRAC_BITS = 14;
  // four 31-bit-range products summed need two guard bits
  localparam int SUM_W     = 34;
  localparam int Q_W       = SUM_W - FRAC_BITS + 1;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // register index, taken from the word address bit
  localparam logic REG_SWAP_FEEDS = 1'b0;

  localparam logic signed [SUM_W:0] ROUND_HALF = (SUM_W + 1)'(1 << (FRAC_BITS - 1));
  localparam logic [PART_W-1:0]     SAT_POS    = {1'b0, {(PART_W - 1){1'b1}}};
  localparam logic [PART_W-1:0]     SAT_NEG    = {1'b1, {(PART_W - 1){1'b0}}};

  // round half up, floor shift by FRAC_BITS, saturate to PART_W bits
  function automatic logic [PART_W-1:0] narrow(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W:0] r;
    logic        [Q_W-1:0] q;
    logic [PART_W-1:0]     res;
    r = (SUM_W + 1)'(s) + ROUND_HALF;
    q = r[SUM_W:FRAC_BITS];
    if (!q[Q_W-1] && (|q[Q_W-2:PART_W-1])) begin
      res = SAT_POS;
    end else if (q[Q_W-1] && !(&q[Q_W-2:PART_W-1])) begin
      res = SAT_NEG;
    end else begin
      res = q[PART_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pma_mac2.sv @@
// Complex a*x + b*y with optional conjugation of a and b: product register, then sum and narrow.
`default_nettype none

module pma_mac2 (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire pma_pkg::cpx_t a,
  input  wire pma_pkg::cpx_t x,
  input  wire pma_pkg::cpx_t b,
  input  wire pma_pkg::cpx_t y,
  input  wire logic          cj,
  output logic [31:0]        result
);

  logic signed [31:0] ar_xr_r, ai_xi_r, ar_xi_r, ai_xr_r;
  logic signed [31:0] br_yr_r, bi_yi_r, br_yi_r, bi_yr_r;
  logic               cj_r;

  logic signed [pma_pkg::SUM_W-1:0] sum_re, sum_im;
  logic signed [pma_pkg::SUM_W-1:0] e_ar_xr, e_ai_xi, e_ar_xi, e_ai_xr;
  logic signed [pma_pkg::SUM_W-1:0] e_br_yr, e_bi_yi, e_br_yi, e_bi_yr;

  always_ff @(posedge clk) begin
    if (load) begin
      ar_xr_r <= a.re * x.re;
      ai_xi_r <= a.im * x.im;
      ar_xi_r <= a.re * x.im;
      ai_xr_r <= a.im * x.re;
      br_yr_r <= b.re * y.re;
      bi_yi_r <= b.im * y.im;
      br_yi_r <= b.re * y.im;
      bi_yr_r <= b.im * y.re;
      cj_r    <= cj;
    end
  end

  assign e_ar_xr = pma_pkg::SUM_W'(ar_xr_r);
  assign e_ai_xi = pma_pkg::SUM_W'(ai_xi_r);
  assign e_ar_xi = pma_pkg::SUM_W'(ar_xi_r);
  assign e_ai_xr = pma_pkg::SUM_W'(ai_xr_r);
  assign e_br_yr = pma_pkg::SUM_W'(br_yr_r);
  assign e_bi_yi = pma_pkg::SUM_W'(bi_yi_r);
  assign e_br_yi = pma_pkg::SUM_W'(br_yi_r);
  assign e_bi_yr = pma_pkg::SUM_W'(bi_yr_r);

  // conjugating a and b flips the sign of every imaginary-matrix term
  always_comb begin
    if (cj_r) begin
      sum_re = e_ar_xr + e_ai_xi + e_br_yr + e_bi_yi;
      sum_im = e_ar_xi - e_ai_xr + e_br_yi - e_bi_yr;
    end else begin
      sum_re = e_ar_xr - e_ai_xi + e_br_yr - e_bi_yi;
      sum_im = e_ar_xi + e_ai_xr + e_br_yi + e_bi_yr;
    end
  end

  assign result = {pma_pkg::narrow(sum_re), pma_pkg::narrow(sum_im)};

endmodule

`default_nettype wire

@@ hw/rtl/polarization_matrix_apply_unit.sv @@
// Top level: applies a 2x2 complex conversion matrix to the four products of one channel.
//
//   port group   direction  handshake          word
//   in_*         in         in_valid/in_stall  4 products, 2x2 matrix, conj_mode, last flag
//   out_*        out        out_valid/out_stall 4 converted products, last flag
//   cfg_*        in/out     APB, pready high   swap_feeds at byte address 0
//
// One word per cycle sustained while out_stall is low; a taken word passes the input,
// product and result registers. Pace is one word per cycle through all three stages,
// with 32 16x16 multipliers working in parallel in the product stage.
// Synchronous reset clears the stage valid bits and swap_feeds.
// A stalled result holds; earlier stages keep filling until every stage is occupied.
`default_nettype none

module polarization_matrix_apply_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [31:0]                   in_vis_slot0,
  input  wire logic [31:0]                   in_vis_slot1,
  input  wire logic [31:0]                   in_vis_slot2,
  input  wire logic [31:0]                   in_vis_slot3,
  input  wire logic [31:0]                   in_mat_row0_col0,
  input  wire logic [31:0]                   in_mat_row0_col1,
  input  wire logic [31:0]                   in_mat_row1_col0,
  input  wire logic [31:0]                   in_mat_row1_col1,
  input  wire logic                          in_conj_mode,
  input  wire logic                          in_last_channel,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [31:0]                        out_p11,
  output logic [31:0]                        out_p22,
  output logic [31:0]                        out_p12,
  output logic [31:0]                        out_p21,
  output logic                               out_last,

  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [pma_pkg::PADDR_W-1:0]   cfg_paddr,
  input  wire logic [pma_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [pma_pkg::PDATA_W-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  logic swap_feeds_r;
  logic cfg_wr;
  logic cfg_sel_swap;

  // stage 0: input register
  logic          v0_r;
  pma_pkg::cpx_t vis0_r [4];
  pma_pkg::cpx_t m00_r, m01_r, m10_r, m11_r;
  logic          conj0_r, last0_r;

  // stage 1: products (inside the mac units)
  logic v1_r, last1_r;

  // stage 2: result register
  logic        v2_r, last2_r;
  logic [31:0] p11_r, p22_r, p12_r, p21_r;

  logic rdy0, rdy1, rdy2;
  logic load1, load2;

  pma_pkg::cpx_t v11, v12, v21, v22;
  pma_pkg::cpx_t b_11, b_22, b_12, b_21;
  pma_pkg::cpx_t a_22, a_12, a_21;
  pma_pkg::cpx_t x_22, x_12, x_21;
  pma_pkg::cpx_t y_11, y_22, y_12, y_21;
  logic [31:0]   r11, r22, r12, r21;

  // configuration
  assign cfg_pready   = 1'b1;
  assign cfg_sel_swap = (cfg_paddr[2] == pma_pkg::REG_SWAP_FEEDS);
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_swap;
  assign cfg_prdata   = cfg_sel_swap ? pma_pkg::PDATA_W'(swap_feeds_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_feeds_r <= 1'b0;
    end else if (cfg_wr) begin
      swap_feeds_r <= cfg_pwdata[0];
    end
  end

  // pipeline flow: a stage moves on when the next one is free or moving
  assign rdy2     = !v2_r || !out_stall;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_stall = !rdy0;
  assign load1    = rdy1 && v0_r;
  assign load2    = rdy2 && v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      vis0_r[0] <= in_vis_slot0;
      vis0_r[1] <= in_vis_slot1;
      vis0_r[2] <= in_vis_slot2;
      vis0_r[3] <= in_vis_slot3;
      m00_r     <= in_mat_row0_col0;
      m01_r     <= in_mat_row0_col1;
      m10_r     <= in_mat_row1_col0;
      m11_r     <= in_mat_row1_col1;
      conj0_r   <= in_conj_mode;
      last0_r   <= in_last_channel;
    end
    if (load1) begin
      last1_r <= last0_r;
    end
    if (load2) begin
      p11_r   <= r11;
      p22_r   <= r22;
      p12_r   <= r12;
      p21_r   <= r21;
      last2_r <= last1_r;
    end
  end

  // slot to product mapping
  always_comb begin
    priority if (!swap_feeds_r) begin
      v11 = vis0_r[0]; v22 = vis0_r[1]; v12 = vis0_r[2]; v21 = vis0_r[3];
    end else if (conj0_r) begin
      v21 = vis0_r[0]; v12 = vis0_r[1]; v22 = vis0_r[2]; v11 = vis0_r[3];
    end else begin
      v12 = vis0_r[0]; v21 = vis0_r[1]; v11 = vis0_r[2]; v22 = vis0_r[3];
    end
  end

  // operand routing: M*V when conj_mode is set, V*conj(M) otherwise
  assign a_22 = conj0_r ? m10_r : m01_r;
  assign a_12 = conj0_r ? m00_r : m01_r;
  assign a_21 = conj0_r ? m10_r : m00_r;
  assign b_11 = conj0_r ? m01_r : m10_r;
  assign b_22 = m11_r;
  assign b_12 = conj0_r ? m01_r : m11_r;
  assign b_21 = conj0_r ? m11_r : m10_r;
  assign x_22 = conj0_r ? v12 : v21;
  assign x_12 = conj0_r ? v12 : v11;
  assign x_21 = conj0_r ? v11 : v21;
  assign y_11 = conj0_r ? v21 : v12;
  assign y_22 = v22;
  assign y_12 = conj0_r ? v22 : v12;
  assign y_21 = conj0_r ? v21 : v22;

  pma_mac2 u_mac_11 (
    .clk(clk), .load(load1), .a(m00_r), .x(v11), .b(b_11), .y(y_11),
    .cj(!conj0_r), .result(r11)
  );

  pma_mac2 u_mac_22 (
    .clk(clk), .load(load1), .a(a_22), .x(x_22), .b(b_22), .y(y_22),
    .cj(!conj0_r), .result(r22)
  );

  pma_mac2 u_mac_12 (
    .clk(clk), .load(load1), .a(a_12), .x(x_12), .b(b_12), .y(y_12),
    .cj(!conj0_r), .result(r12)
  );

  pma_mac2 u_mac_21 (
    .clk(clk), .load(load1), .a(a_21), .x(x_21), .b(b_21), .y(y_21),
    .cj(!conj0_r), .result(r21)
  );

  assign out_valid = v2_r;
  assign out_p11   = p11_r;
  assign out_p22   = p22_r;
  assign out_p12   = p12_r;
  assign out_p21   = p21_r;
  assign out_last  = last2_r;

  // input only backs up when every stage holds a word and the output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v0_r && v1_r && v2_r && out_stall))
    else $error("input stalled with a free stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!v0_r && !v1_r && !v2_r))
    else $error("pipeline not empty after reset");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v0_r)
    else $error("accepted word not held in input stage");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> (v1_r && v2_r))
    else $error("product stage word lost under stall");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (swap_feeds_r == $past(cfg_pwdata[0])))
    else $error("swap_feeds write not taken");

endmodule

`default_nettype wire

@@ sim/tb_polarization_matrix_apply_unit.sv @@
// Self-checking testbench for the polarisation matrix apply unit: stimulus queue, predictor, result checker.
module tb_polarization_matrix_apply_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CLK_PERIOD   = 10;
  localparam int     RESET_CYCLES = 12;
  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     DRAIN_CYCLES = 10;
  localparam int     PHASE_WORDS  = 89;
  localparam int     VIS_MODERATE = 8192;
  localparam int     MAT_MODERATE = 16384;
  localparam longint ROUND_BIAS   = 64'sd8192;
  localparam longint PART_MAX     = 64'sd32767;
  localparam longint PART_MIN     = -64'sd32768;

  localparam logic [pma_pkg::PADDR_W-1:0] ADDR_SWAP  = {pma_pkg::REG_SWAP_FEEDS, 2'b00};
  localparam logic [pma_pkg::PADDR_W-1:0] ADDR_SPARE = {~pma_pkg::REG_SWAP_FEEDS, 2'b00};

  typedef pma_pkg::cpx_t cpx_t;

  typedef struct packed {
    cpx_t [3:0]      vis;
    cpx_t [1:0][1:0] mat;
    logic            conj_mode;
    logic            last;
  } channel_word_t;

  typedef struct packed {
    logic [31:0] p11;
    logic [31:0] p22;
    logic [31:0] p12;
    logic [31:0] p21;
    logic        last;
  } converted_t;

  typedef enum logic [1:0] {PART_FULL, PART_MODERATE, PART_EDGE, PART_MIXED} part_kind_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  channel_word_t                 drive_word = '0;
  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  logic [31:0]                   out_p11, out_p22, out_p12, out_p21;
  logic                          out_last;
  logic                          cfg_psel    = 1'b0;
  logic                          cfg_penable = 1'b0;
  logic                          cfg_pwrite  = 1'b0;
  logic [pma_pkg::PADDR_W-1:0]   cfg_paddr   = '0;
  logic [pma_pkg::PDATA_W-1:0]   cfg_pwdata  = '0;
  logic [pma_pkg::PDATA_W-1:0]   cfg_prdata;
  logic                          cfg_pready;

  channel_word_t channel_words[$];
  converted_t    converted_due[$];
  logic          swap_model = 1'b0;

  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  int   tx_calm      = 0;
  int   rx_calm      = 0;
  bit   tx_idle_now;
  bit   rx_stall_now;
  int   n_errors     = 0;
  int   n_sent       = 0;
  int   n_results    = 0;
  int   n_directed   = 0;
  int   n_cfg        = 0;
  int   cycle_count  = 0;
  converted_t got, want;

  polarization_matrix_apply_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_vis_slot0     (drive_word.vis[0]),
    .in_vis_slot1     (drive_word.vis[1]),
    .in_vis_slot2     (drive_word.vis[2]),
    .in_vis_slot3     (drive_word.vis[3]),
    .in_mat_row0_col0 (drive_word.mat[0][0]),
    .in_mat_row0_col1 (drive_word.mat[0][1]),
    .in_mat_row1_col0 (drive_word.mat[1][0]),
    .in_mat_row1_col1 (drive_word.mat[1][1]),
    .in_conj_mode     (drive_word.conj_mode),
    .in_last_channel  (drive_word.last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_p11          (out_p11),
    .out_p22          (out_p22),
    .out_p12          (out_p12),
    .out_p21          (out_p21),
    .out_last         (out_last),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor
  function automatic logic [15:0] round_saturate(input longint s);
    longint q;
    q = (s + ROUND_BIAS) >>> pma_pkg::FRAC_BITS;
    if (q > PART_MAX) begin
      q = PART_MAX;
    end else if (q < PART_MIN) begin
      q = PART_MIN;
    end
    return q[15:0];
  endfunction

  // a*x + b*y, a and b conjugated on request
  function automatic logic [31:0] cmac(input cpx_t a, input cpx_t x, input cpx_t b,
                                       input cpx_t y, input logic conj_m);
    longint ar, ai, br, bi, xr, xi, yr, yi;
    ar = longint'($signed(a.re));
    ai = longint'($signed(a.im));
    br = longint'($signed(b.re));
    bi = longint'($signed(b.im));
    xr = longint'($signed(x.re));
    xi = longint'($signed(x.im));
    yr = longint'($signed(y.re));
    yi = longint'($signed(y.im));
    if (conj_m) begin
      ai = -ai;
      bi = -bi;
    end
    return {round_saturate(ar * xr - ai * xi + br * yr - bi * yi),
            round_saturate(ar * xi + ai * xr + br * yi + bi * yr)};
  endfunction

  function automatic converted_t convert_channel(input channel_word_t w, input logic swap);
    converted_t r;
    cpx_t v11, v12, v21, v22;
    if (!swap) begin
      v11 = w.vis[0]; v22 = w.vis[1]; v12 = w.vis[2]; v21 = w.vis[3];
    end else if (w.conj_mode) begin
      v21 = w.vis[0]; v12 = w.vis[1]; v22 = w.vis[2]; v11 = w.vis[3];
    end else begin
      v12 = w.vis[0]; v21 = w.vis[1]; v11 = w.vis[2]; v22 = w.vis[3];
    end
    if (w.conj_mode) begin
      r.p11 = cmac(w.mat[0][0], v11, w.mat[0][1], v21, 1'b0);
      r.p22 = cmac(w.mat[1][0], v12, w.mat[1][1], v22, 1'b0);
      r.p12 = cmac(w.mat[0][0], v12, w.mat[0][1], v22, 1'b0);
      r.p21 = cmac(w.mat[1][0], v11, w.mat[1][1], v21, 1'b0);
    end else begin
      r.p11 = cmac(w.mat[0][0], v11, w.mat[1][0], v12, 1'b1);
      r.p22 = cmac(w.mat[0][1], v21, w.mat[1][1], v22, 1'b1);
      r.p12 = cmac(w.mat[0][1], v11, w.mat[1][1], v12, 1'b1);
      r.p21 = cmac(w.mat[0][0], v21, w.mat[1][0], v22, 1'b1);
    end
    r.last = w.last;
    return r;
  endfunction

  // stimulus
  function automatic logic [15:0] random_part(input part_kind_t kind, input int lim);
    part_kind_t k;
    k = kind;
    if (k == PART_MIXED) begin
      k = part_kind_t'($urandom_range(0, 2));
    end
    case (k)
      PART_FULL: begin
        return 16'($urandom);
      end
      PART_MODERATE: begin
        return 16'($urandom_range(0, 2 * lim) - lim);
      end
      default: begin
        case ($urandom_range(0, 7))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'hFFFF;
          4: return 16'h0001;
          5: return 16'h4000;
          6: return 16'hC000;
          default: return 16'h2000;
        endcase
      end
    endcase
  endfunction

  function automatic part_kind_t pick_kind();
    int p;
    p = $urandom_range(0, 9);
    if (p < 4) begin
      return PART_FULL;
    end else if (p < 8) begin
      return PART_MODERATE;
    end else if (p == 8) begin
      return PART_EDGE;
    end
    return PART_MIXED;
  endfunction

  function automatic channel_word_t random_channel();
    channel_word_t w;
    part_kind_t vk, mk;
    vk = pick_kind();
    mk = pick_kind();
    for (int k = 0; k < 4; k++) begin
      w.vis[k].re = random_part(vk, VIS_MODERATE);
      w.vis[k].im = random_part(vk, VIS_MODERATE);
      w.mat[k / 2][k % 2].re = random_part(mk, MAT_MODERATE);
      w.mat[k / 2][k % 2].im = random_part(mk, MAT_MODERATE);
    end
    w.conj_mode = 1'($urandom_range(0, 1));
    w.last      = ($urandom_range(0, 7) == 0);
    return w;
  endfunction

  function automatic channel_word_t make_word(input logic [31:0] v0, v1, v2, v3,
                                              input logic [31:0] m00, m01, m10, m11,
                                              input logic cj, input logic lst);
    channel_word_t w;
    w.vis[0] = v0; w.vis[1] = v1; w.vis[2] = v2; w.vis[3] = v3;
    w.mat[0][0] = m00; w.mat[0][1] = m01; w.mat[1][0] = m10; w.mat[1][1] = m11;
    w.conj_mode = cj;
    w.last      = lst;
    return w;
  endfunction

  task automatic push_word(input channel_word_t w);
    channel_words.push_back(w);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        converted_due.push_back(convert_channel(drive_word, swap_model));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        tx_idle_now = 1'b0;
        if (tx_calm > 0) begin
          tx_calm--;
        end else if ($urandom_range(0, 63) == 0) begin
          tx_calm = $urandom_range(8, 40);
        end else begin
          tx_idle_now = ($urandom_range(0, 99) < tx_idle_pct);
        end
        if (!tx_idle_now && channel_words.size() != 0) begin
          drive_word <= channel_words.pop_front();
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (actv !== expv) begin
      $display("%0t: word %0d %s mismatch: expected %h, got %h",
               $time, n_results, name, expv, actv);
      n_errors++;
    end
  endtask

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{p11: out_p11, p22: out_p22, p12: out_p12, p21: out_p21, last: out_last};
        if (converted_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h", $time, got);
          n_errors++;
        end else begin
          want = converted_due.pop_front();
          check_field("p11", want.p11, got.p11);
          check_field("p22", want.p22, got.p22);
          check_field("p12", want.p12, got.p12);
          check_field("p21", want.p21, got.p21);
          check_field("last", 32'(want.last), 32'(got.last));
        end
        n_results++;
      end
      rx_stall_now = 1'b0;
      if (rx_calm > 0) begin
        rx_calm--;
      end else if ($urandom_range(0, 63) == 0) begin
        rx_calm = $urandom_range(8, 40);
      end else begin
        rx_stall_now = ($urandom_range(0, 99) < rx_stall_pct);
      end
      out_stall <= rx_stall_now;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, converted_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // register access
  task automatic cfg_write(input logic [pma_pkg::PADDR_W-1:0] addr,
                           input logic [pma_pkg::PDATA_W-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_SWAP) begin
      swap_model = data[0];
    end
    n_cfg++;
  endtask

  task automatic cfg_check_swap();
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_SWAP;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== pma_pkg::PDATA_W'(swap_model)) begin
      $display("%0t: swap_feeds readback mismatch: expected %h, got %h",
               $time, pma_pkg::PDATA_W'(swap_model), cfg_prdata);
      n_errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    n_cfg++;
  endtask

  task automatic wait_drained();
    while (channel_words.size() != 0 || in_valid || converted_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_random(input int n_words, input int tx_pct, input int rx_pct);
    @(negedge clk);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < n_words; i++) begin
      push_word(random_channel());
    end
    wait_drained();
  endtask

  initial begin
    swap_model = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    cfg_check_swap();

    // directed words, swap_feeds at reset value
    @(negedge clk);
    tx_idle_pct  = 33;
    rx_stall_pct = 54;
    push_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    // identity matrix with distinct slots shows the slot mapping
    push_word(make_word(32'h0001_0002, 32'h0003_0004, 32'h0005_0006, 32'h0007_0008,
                        32'h4000_0000, 0, 0, 32'h4000_0000, 1'b1, 1'b0));
    push_word(make_word(32'h0001_0002, 32'h0003_0004, 32'h0005_0006, 32'h0007_0008,
                        32'h4000_0000, 0, 0, 32'h4000_0000, 1'b0, 1'b1));
    // asymmetric matrix with imaginary parts, both orders of product
    push_word(make_word(32'h0123_FE11, 32'hF456_0789, 32'h0ABC_F321, 32'h1000_0FFF,
                        32'h1000_0400, 32'h0800_F000, 32'hF800_0200, 32'h2000_E000,
                        1'b1, 1'b0));
    push_word(make_word(32'h0123_FE11, 32'hF456_0789, 32'h0ABC_F321, 32'h1000_0FFF,
                        32'h1000_0400, 32'h0800_F000, 32'hF800_0200, 32'h2000_E000,
                        1'b0, 1'b0));
    // saturation at both rails
    for (int cj = 0; cj < 2; cj++) begin
      push_word(make_word(32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                          32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                          1'(cj), 1'b0));
      push_word(make_word(32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                          32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                          1'(cj), 1'b1));
    end
    push_word(make_word(32'h7FFF_8000, 32'h8000_7FFF, 32'h7FFF_8000, 32'h8000_7FFF,
                        32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                        1'b1, 1'b0));
    // rounding: exact half goes up, just below half goes down
    push_word(make_word(32'h0001_FFFF, 32'h0001_FFFF, 32'h0001_FFFF, 32'h0001_FFFF,
                        32'h2000_0000, 0, 0, 0, 1'b1, 1'b0));
    push_word(make_word(32'h0001_FFFF, 32'h0001_FFFF, 32'h0001_FFFF, 32'h0001_FFFF,
                        32'h2000_0000, 0, 0, 0, 1'b0, 1'b0));
    push_word(make_word(32'h0001_FFFF, 32'h0001_FFFF, 32'h0001_FFFF, 32'h0001_FFFF,
                        32'h1FFF_0000, 0, 0, 0, 1'b1, 1'b1));
    push_word(make_word('1, '1, '1, '1, '1, '1, '1, '1, 1'b0, 1'b1));
    n_directed = channel_words.size();
    wait_drained();

    // only bit 0 is kept; the spare address is ignored
    cfg_write(ADDR_SWAP, 32'hFFFF_FFFF);
    cfg_write(ADDR_SPARE, 32'h0000_0000);
    cfg_check_swap();
    run_random(PHASE_WORDS, 33, 54);

    cfg_write(ADDR_SWAP, 32'hFFFF_FFFE);
    cfg_write(ADDR_SPARE, 32'h0000_0001);
    cfg_check_swap();
    run_random(PHASE_WORDS, 33, 54);

    cfg_write(ADDR_SWAP, 32'h0000_0001);
    run_random(PHASE_WORDS, 54, 33);
    cfg_write(ADDR_SWAP, 32'h8000_0000);
    cfg_check_swap();
    run_random(PHASE_WORDS, 54, 33);

    cfg_write(ADDR_SWAP, 32'h0000_0001);
    run_random(PHASE_WORDS, 0, 0);
    cfg_write(ADDR_SWAP, 32'h0000_0000);
    run_random(PHASE_WORDS, 0, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d channel words (%0d directed) under both feed mappings and three pacing",
             n_sent, n_directed);
    $display("modes; checked %0d results and %0d register accesses.", n_results, n_cfg);
    if (n_errors == 0 && converted_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
